// ----- sv/sha_pkg.sv -----
// Package for the SHA-256 stream hash block.
// Holds the round constants, initial hash values and shared types.
package sha_pkg;

  localparam int NumRounds = 64;

  typedef logic [31:0] word_t;

  typedef struct packed {
    logic load_word;
    logic start;
    logic pad_word;
    word_t pad_value;
    logic init;
  } dp_cmd_t;

  typedef struct packed {
    logic busy;
  } dp_stat_t;

  function automatic word_t round_k(input logic [5:0] idx);
    word_t k;
    unique case (idx)
      6'd0: k = 32'h428a2f98; 6'd1: k = 32'h71374491; 6'd2: k = 32'hb5c0fbcf;
      6'd3: k = 32'he9b5dba5; 6'd4: k = 32'h3956c25b; 6'd5: k = 32'h59f111f1;
      6'd6: k = 32'h923f82a4; 6'd7: k = 32'hab1c5ed5; 6'd8: k = 32'hd807aa98;
      6'd9: k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
      6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
      6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
      6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
      6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
      6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
      6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
      6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
      6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
      default: k = 32'hc67178f2;
    endcase
    return k;
  endfunction

  function automatic word_t initial_h(input logic [2:0] idx);
    word_t h;
    unique case (idx)
      3'd0: h = 32'h6a09e667; 3'd1: h = 32'hbb67ae85; 3'd2: h = 32'h3c6ef372;
      3'd3: h = 32'ha54ff53a; 3'd4: h = 32'h510e527f; 3'd5: h = 32'h9b05688c;
      3'd6: h = 32'h1f83d9ab;
      default: h = 32'h5be0cd19;
    endcase
    return h;
  endfunction

  function automatic word_t rotr(input word_t x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

endpackage

// ----- sv/sha_if.sv -----
// Valid/ready channel interfaces for the SHA-256 stream hash block.
// Depends on nothing.
interface sha_in_if;
  logic valid;
  logic ready;
  logic opcode;
  logic [7:0] data_byte;
  modport source(output valid, output opcode, output data_byte, input ready);
  modport sink(input valid, input opcode, input data_byte, output ready);
endinterface

interface sha_out_if;
  logic valid;
  logic ready;
  logic [31:0] digest_word;
  logic [2:0] word_index;
  logic last_word;
  modport source(output valid, output digest_word, output word_index, output last_word,
                 input ready);
  modport sink(input valid, input digest_word, input word_index, input last_word,
               output ready);
endinterface

// ----- sv/sha_datapath.sv -----
// SHA-256 datapath: message schedule window, working variables and chain words.
// Depends on sha_pkg; commanded by sha_ctrl.
module sha_datapath
  import sha_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  dp_cmd_t cmd,
  input  word_t in_word,
  input  logic [2:0] rd_index,
  output word_t rd_word,
  output dp_stat_t stat
);

  word_t chain [8];
  word_t v [8];
  word_t w [16];
  logic [5:0] round;
  logic running;

  word_t w_next, wt, s0, s1, t1, t2, e, a;

  assign s0 = rotr(w[1], 7) ^ rotr(w[1], 18) ^ (w[1] >> 3);
  assign s1 = rotr(w[14], 17) ^ rotr(w[14], 19) ^ (w[14] >> 10);
  assign w_next = s1 + w[9] + s0 + w[0];
  assign wt = w[0];
  assign e = v[4];
  assign a = v[0];
  assign t1 = v[7] + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & v[5]) ^ (~e & v[6]))
              + round_k(round) + wt;
  assign t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & v[1]) ^ (a & v[2]) ^ (v[1] & v[2]));

  assign rd_word = chain[rd_index];
  assign stat.busy = running;

  always_ff @(posedge clk) begin
    if (cmd.load_word) begin
      for (int i = 0; i < 15; i++) w[i] <= w[i+1];
      w[15] <= in_word;
    end else if (cmd.pad_word) begin
      for (int i = 0; i < 15; i++) w[i] <= w[i+1];
      w[15] <= cmd.pad_value;
    end else if (running) begin
      for (int i = 0; i < 15; i++) w[i] <= w[i+1];
      w[15] <= w_next;
    end
    if (cmd.start) begin
      for (int i = 0; i < 8; i++) v[i] <= chain[i];
    end else if (running) begin
      v[7] <= v[6]; v[6] <= v[5]; v[5] <= v[4]; v[4] <= v[3] + t1;
      v[3] <= v[2]; v[2] <= v[1]; v[1] <= v[0]; v[0] <= t1 + t2;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.init) begin
      for (int i = 0; i < 8; i++) chain[i] <= initial_h(3'(i));
      running <= 1'b0;
      round <= '0;
    end else if (cmd.start) begin
      running <= 1'b1;
      round <= '0;
    end else if (running) begin
      round <= round + 6'd1;
      if (round == 6'(NumRounds - 1)) begin
        running <= 1'b0;
        chain[0] <= chain[0] + t1 + t2;
        chain[1] <= chain[1] + v[0];
        chain[2] <= chain[2] + v[1];
        chain[3] <= chain[3] + v[2];
        chain[4] <= chain[4] + v[3] + t1;
        chain[5] <= chain[5] + v[4];
        chain[6] <= chain[6] + v[5];
        chain[7] <= chain[7] + v[6];
      end
    end
  end

  a_no_restart: assert property (@(posedge clk) disable iff (rst)
    !(cmd.start && running))
    else $error("start while compressing");
  a_round_range: assert property (@(posedge clk) disable iff (rst)
    !running |-> round == 6'd0 || $past(round) == 6'(NumRounds - 1) || $past(cmd.start))
    else $error("round counter moved while idle");
  a_busy_stop: assert property (@(posedge clk) disable iff (rst)
    running && round == 6'(NumRounds - 1) |=> !running)
    else $error("compression did not stop after the last round");
  a_no_load: assert property (@(posedge clk) disable iff (rst)
    running |-> !cmd.load_word && !cmd.pad_word)
    else $error("schedule written during compression");

endmodule

// ----- sv/sha_ctrl.sv -----
// Controller for the SHA-256 stream hash: byte packing, padding and digest output.
// Depends on sha_pkg; drives sha_datapath through dp_cmd_t.
module sha_ctrl
  import sha_pkg::*;
(
  input  logic clk,
  input  logic rst,
  sha_in_if.sink in_ch,
  sha_out_if.source out_ch,
  output dp_cmd_t cmd,
  output word_t in_word,
  output logic [2:0] rd_index,
  input  word_t rd_word,
  input  dp_stat_t stat
);

  typedef enum logic [5:0] {
    S_ABSORB = 6'b000001,
    S_COMP   = 6'b000010,
    S_PAD    = 6'b000100,
    S_PCOMP  = 6'b001000,
    S_OUT    = 6'b010000,
    S_WAIT   = 6'b100000
  } state_t;

  state_t state;
  logic [5:0] fill;
  logic [60:0] msg_bytes;
  logic [23:0] part;
  logic second;
  logic [3:0] pad_cnt;
  logic [2:0] out_idx;
  logic out_valid;
  word_t out_word;
  logic [63:0] bits;
  logic [3:0] word_pos;
  logic [1:0] byte_pos;
  word_t pad_val;

  assign bits = {msg_bytes, 3'b000};
  assign word_pos = fill[5:2];
  assign byte_pos = fill[1:0];
  assign in_ch.ready = (state == S_ABSORB) && !stat.busy;
  assign in_word = {part, in_ch.data_byte};
  assign rd_index = out_idx;
  assign out_ch.valid = out_valid;
  assign out_ch.digest_word = out_word;
  assign out_ch.word_index = out_idx;
  assign out_ch.last_word = out_idx == 3'd7;

  always_comb begin
    pad_val = '0;
    if (!second && pad_cnt == word_pos) begin
      unique case (byte_pos)
        2'd0: pad_val = 32'h80000000;
        2'd1: pad_val = {part[7:0], 24'h800000};
        2'd2: pad_val = {part[15:0], 16'h8000};
        default: pad_val = {part[23:0], 8'h80};
      endcase
    end
    if (pad_cnt == 4'd14 && (second || fill < 6'd56)) pad_val = bits[63:32];
    if (pad_cnt == 4'd15 && (second || fill < 6'd56)) pad_val = bits[31:0];
  end

  always_comb begin
    cmd = '0;
    cmd.load_word = in_ch.valid && in_ch.ready && !in_ch.opcode && byte_pos == 2'd3;
    cmd.pad_word = (state == S_PAD) && (second || pad_cnt >= word_pos);
    cmd.pad_value = pad_val;
    cmd.start = (state == S_COMP) || (state == S_PCOMP);
    cmd.init = (state == S_WAIT) && !stat.busy && out_valid && out_ch.ready && out_idx == 3'd7;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_ABSORB;
      fill <= '0;
      msg_bytes <= '0;
      second <= 1'b0;
      pad_cnt <= '0;
      out_idx <= '0;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        S_ABSORB: begin
          if (in_ch.valid && in_ch.ready) begin
            if (!in_ch.opcode) begin
              part <= {part[15:0], in_ch.data_byte};
              fill <= fill + 6'd1;
              msg_bytes <= msg_bytes + 61'd1;
              if (fill == 6'd63) state <= S_COMP;
            end else begin
              pad_cnt <= '0;
              second <= 1'b0;
              state <= S_PAD;
            end
          end
        end
        S_COMP: state <= S_ABSORB;
        S_PAD: begin
          pad_cnt <= pad_cnt + 4'd1;
          if (pad_cnt == 4'd15) state <= S_PCOMP;
        end
        S_PCOMP: begin
          if (!second && fill >= 6'd56) begin
            second <= 1'b1;
            state <= S_WAIT;
          end else begin
            second <= 1'b0;
            state <= S_WAIT;
          end
        end
        S_WAIT: begin
          if (!stat.busy) begin
            if (second && !out_valid) begin
              state <= S_PAD;
            end else if (!out_valid) begin
              out_valid <= 1'b1;
              out_word <= rd_word;
            end else if (out_ch.ready) begin
              if (out_idx == 3'd7) begin
                out_valid <= 1'b0;
                out_idx <= '0;
                fill <= '0;
                msg_bytes <= '0;
                second <= 1'b0;
                state <= S_ABSORB;
              end else begin
                out_valid <= 1'b0;
                out_idx <= out_idx + 3'd1;
              end
            end
          end
        end
        default: state <= S_ABSORB;
      endcase
    end
  end

  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    in_ch.ready |-> !out_valid) else $error("input taken while digest pending");
  a_load_absorb: assert property (@(posedge clk) disable iff (rst)
    cmd.load_word |-> state == S_ABSORB) else $error("word load outside absorb");
  a_out_wait: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> state == S_WAIT) else $error("output outside drain state");

endmodule

// ----- sv/sha256_stream_hash.sv -----
// SHA-256 over a byte stream, one byte per input transaction, digest as eight
// output transactions. Data bytes are taken back to back, but after every 64th byte
// input is held off while the round unit is started and runs 64 rounds. A finish
// pads the message and spends a start and 64 rounds on each padded block; a second
// block, needed when 56 or more bytes are pending, goes through the wait state
// before its padding. Digest words are registered, valid drops after each accepted
// word, and the next transaction is taken in the cycle after the last is accepted.
module sha256_stream_hash
  import sha_pkg::*;
(
  input logic clk,
  input logic rst,
  sha_in_if.sink in_ch,
  sha_out_if.source out_ch
);

  dp_cmd_t cmd;
  dp_stat_t stat;
  word_t in_word;
  word_t rd_word;
  logic [2:0] rd_index;

  sha_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch), .cmd(cmd), .in_word(in_word),
    .rd_index(rd_index), .rd_word(rd_word), .stat(stat)
  );

  sha_datapath u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .in_word(in_word), .rd_index(rd_index),
    .rd_word(rd_word), .stat(stat)
  );

endmodule
